// File: sv/vrp_pkg.sv
// ---------------------------------------------------------------------------
// vrp_pkg: shared constants and types for the vertex rotate/project unit
// Holds the fixed-point formats, the sine polynomial, register codes and
// pipeline stage counts used by the unit and its submodules.
// ---------------------------------------------------------------------------
package vrp_pkg;

	localparam int COORD_FRAC_BITS = 14;
	localparam int EXTRA_BITS      = 14;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int PIXEL_BITS_DEF  = 12;

	localparam int IN_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int TRIG_W  = 32;
	localparam int COORD_W = 32;
	localparam int DEN_W   = 32;
	localparam int QUOT_W  = 35;
	localparam int MAG_W   = 41;
	localparam int NUM_W   = MAG_W + 16;
	localparam int SWAY_W  = 28;

	localparam int SINE_STAGES = 7;
	localparam int ROT_STAGES  = 2;
	localparam int DIV_STAGES  = QUOT_W;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	localparam logic [31:0] SINE_POLY [5] = '{
		32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X          = 3'd0,
		REG_CENTER_Y          = 3'd1,
		REG_SCREEN_SCALE      = 3'd2,
		REG_SWAY_AMPLITUDE    = 3'd3,
		REG_EYE_DISTANCE_BASE = 3'd4
	} cfg_reg_t;

	localparam logic [10:0] CENTER_X_RST  = 11'd320;
	localparam logic [10:0] CENTER_Y_RST  = 11'd320;
	localparam logic [9:0]  SCALE_RST     = 10'd160;
	localparam logic [9:0]  SWAY_AMP_RST  = 10'd100;
	localparam logic [15:0] EYE_DIST_RST  = 16'd32768;

	typedef struct packed {
		logic                      neg_x;
		logic                      neg_y;
		logic signed [SWAY_W-1:0]  sway;
		logic                      clip;
	} vrp_side_t;

endpackage

// File: sv/vrp_sine.sv
// ---------------------------------------------------------------------------
// vrp_sine: pipelined Q30 sine of a 32-bit turn fraction
// Folds the turn into a quarter wave and evaluates an odd polynomial in
// Horner form, at most one multiplication per stage, seven stages in all.
// ---------------------------------------------------------------------------
module vrp_sine (
	input  logic                                clk,
	input  logic                                en,
	input  logic [31:0]                         turn,
	output logic signed [vrp_pkg::TRIG_W-1:0]   sine
);

	logic [30:0] x_fold;
	logic [61:0] xx;

	logic [30:0] x_s    [1:5];
	logic [30:0] x2_s   [1:4];
	logic [1:0]  quad_s [1:6];
	logic [31:0] p_s    [1:5];
	logic [31:0] sm_s6;
	logic [31:0] mag;
	logic signed [vrp_pkg::TRIG_W-1:0] sine_s7;

	assign x_fold = turn[30] ? (31'(vrp_pkg::Q30_ONE) - {1'b0, turn[29:0]})
	                         : {1'b0, turn[29:0]};
	assign xx  = 62'(x_fold) * 62'(x_fold);
	assign mag = (sm_s6 > vrp_pkg::Q30_ONE) ? vrp_pkg::Q30_ONE : sm_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[1]    <= x_fold;
			x2_s[1]   <= 31'(xx >> 30);
			quad_s[1] <= turn[31:30];
			p_s[1]    <= vrp_pkg::SINE_POLY[4];
			for (int k = 2; k <= 5; k++) begin
				x_s[k]    <= x_s[k-1];
				quad_s[k] <= quad_s[k-1];
				p_s[k]    <= vrp_pkg::SINE_POLY[5-k]
				           - 32'((64'(x2_s[k-1]) * 64'(p_s[k-1])) >> 30);
			end
			for (int k = 2; k <= 4; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			quad_s[6] <= quad_s[5];
			sm_s6     <= 32'((64'(x_s[5]) * 64'(p_s[5])) >> 30);
			sine_s7   <= quad_s[6][1] ? -signed'(mag) : signed'(mag);
		end
	end

	assign sine = sine_s7;

endmodule

// File: sv/vrp_rotate.sv
// ---------------------------------------------------------------------------
// vrp_rotate: two-stage plane rotation of a coordinate pair
// Stage one forms the four trig products, stage two combines them and
// rounds half up by 30 bits.
// ---------------------------------------------------------------------------
module vrp_rotate (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [vrp_pkg::TRIG_W-1:0]    c,
	input  logic signed [vrp_pkg::TRIG_W-1:0]    s,
	input  logic signed [vrp_pkg::COORD_W-1:0]   a,
	input  logic signed [vrp_pkg::COORD_W-1:0]   b,
	output logic signed [vrp_pkg::COORD_W-1:0]   oa,
	output logic signed [vrp_pkg::COORD_W-1:0]   ob
);

	localparam logic signed [63:0] RND = 64'sd1 <<< 29;

	logic signed [63:0] ca_s1, sb_s1, sa_s1, cb_s1;
	logic signed [vrp_pkg::COORD_W-1:0] oa_s2, ob_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s1 <= 64'(c) * 64'(a);
			sb_s1 <= 64'(s) * 64'(b);
			sa_s1 <= 64'(s) * 64'(a);
			cb_s1 <= 64'(c) * 64'(b);
			oa_s2 <= vrp_pkg::COORD_W'((ca_s1 - sb_s1 + RND) >>> 30);
			ob_s2 <= vrp_pkg::COORD_W'((sa_s1 + cb_s1 + RND) >>> 30);
		end
	end

	assign oa = oa_s2;
	assign ob = ob_s2;

endmodule

// File: sv/vrp_divide.sv
// ---------------------------------------------------------------------------
// vrp_divide: pipelined restoring divider, two lanes with a shared divisor
// One quotient bit per stage. The dividend's upper bits preload the partial
// remainder, which the dividend width keeps below the minimum divisor.
// ---------------------------------------------------------------------------
module vrp_divide (
	input  logic                                clk,
	input  logic                                en,
	input  logic [vrp_pkg::DEN_W-1:0]           den,
	input  logic [vrp_pkg::NUM_W-1:0]           num_x,
	input  logic [vrp_pkg::NUM_W-1:0]           num_y,
	output logic [vrp_pkg::QUOT_W-1:0]          quot_x,
	output logic [vrp_pkg::QUOT_W-1:0]          quot_y
);

	localparam int QB = vrp_pkg::QUOT_W;
	localparam int DW = vrp_pkg::DEN_W;

	function automatic logic [DW+1:0] div_step(input logic [DW:0] r, input logic nbit,
	                                           input logic [DW-1:0] d);
		logic [DW+1:0] t;
		logic [DW+1:0] diff;
		t    = {r, nbit};
		diff = t - {2'b00, d};
		if (t >= {2'b00, d}) begin
			return {1'b1, diff[DW:0]};
		end
		return {1'b0, t[DW:0]};
	endfunction

	logic [vrp_pkg::NUM_W-1:0] num_l [2];
	logic [DW:0]    r_in  [2];
	logic [DW+1:0]  step  [1:QB][2];

	logic [DW:0]    r_s   [1:QB-1][2];
	logic [QB-1:0]  nlo_s [1:QB-1][2];
	logic [QB-1:0]  q_s   [1:QB][2];
	logic [DW-1:0]  d_s   [1:QB-1];

	assign num_l[0] = num_x;
	assign num_l[1] = num_y;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			r_in[l]    = (DW+1)'(num_l[l] >> QB);
			step[1][l] = div_step(r_in[l], num_l[l][QB-1], den);
			for (int k = 2; k <= QB; k++) begin
				step[k][l] = div_step(r_s[k-1][l], nlo_s[k-1][l][QB-1], d_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[1] <= den;
			for (int k = 2; k <= QB-1; k++) begin
				d_s[k] <= d_s[k-1];
			end
			for (int l = 0; l < 2; l++) begin
				r_s[1][l]   <= step[1][l][DW:0];
				nlo_s[1][l] <= num_l[l][QB-1:0] << 1;
				q_s[1][l]   <= QB'(step[1][l][DW+1]);
				for (int k = 2; k <= QB-1; k++) begin
					r_s[k][l]   <= step[k][l][DW:0];
					nlo_s[k][l] <= nlo_s[k-1][l] << 1;
				end
				for (int k = 2; k <= QB; k++) begin
					q_s[k][l] <= {q_s[k-1][l][QB-2:0], step[k][l][DW+1]};
				end
			end
		end
	end

	assign quot_x = q_s[QB][0];
	assign quot_y = q_s[QB][1];

endmodule

// File: sv/vertex_rotate_project_unit.sv
// ---------------------------------------------------------------------------
// vertex_rotate_project_unit: rotate a vertex about X, Y, Z and project it
// Fully pipelined: sine polynomials, three plane rotations, depth clamp,
// scaling, a restoring divider, centering with sway, and saturation.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_stall    | vertex_x, vertex_y, vertex_z, angle_phase
//   out      | out_valid / out_stall  | pixel_x, pixel_y, clipped
//   config   | cfg_wr_en              | cfg_index, cfg_data
//
// One vertex is taken every cycle unless a stalled result freezes the
// pipeline; most stages lie in the 35-stage divider and seven-stage sine.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline, and in_stall follows it.
// ---------------------------------------------------------------------------
module vertex_rotate_project_unit #(
	parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF,
	parameter int PIXEL_BITS = vrp_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [vrp_pkg::IN_W-1:0]       vertex_x,
	input  logic signed [vrp_pkg::IN_W-1:0]       vertex_y,
	input  logic signed [vrp_pkg::IN_W-1:0]       vertex_z,
	input  logic [vrp_pkg::IN_W-1:0]              angle_phase,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [PIXEL_BITS-1:0]          pixel_x,
	output logic signed [PIXEL_BITS-1:0]          pixel_y,
	output logic                                  clipped
);

	localparam int CFB     = vrp_pkg::COORD_FRAC_BITS;
	localparam int CW      = vrp_pkg::COORD_W;
	localparam int TW      = vrp_pkg::TRIG_W;
	localparam int S_SIN   = 1 + vrp_pkg::SINE_STAGES;
	localparam int S_RX    = S_SIN + vrp_pkg::ROT_STAGES;
	localparam int S_RY    = S_RX + vrp_pkg::ROT_STAGES;
	localparam int S_RZ    = S_RY + vrp_pkg::ROT_STAGES;
	localparam int S_MUL   = S_RZ + 1;
	localparam int S_ABS   = S_MUL + 1;
	localparam int S_DIV   = S_ABS + vrp_pkg::DIV_STAGES;
	localparam int S_SUM   = S_DIV + 1;
	localparam int S_OUT   = S_SUM + 1;
	localparam int SINT_SH = 16 - CFB;

	localparam logic signed [33:0] DMIN =
		34'sd1 <<< (CFB + vrp_pkg::EXTRA_BITS - 6);
	localparam logic signed [33:0] SINT_RND = 34'sd1 <<< (SINT_SH - 1);
	localparam logic signed [39:0] PIX_HI = (40'sd1 <<< (PIXEL_BITS - 1)) - 40'sd1;
	localparam logic signed [39:0] PIX_LO = -(40'sd1 <<< (PIXEL_BITS - 1));

	logic [10:0] cx_q, cy_q;
	logic [9:0]  scale_q, amp_q;
	logic [15:0] eye_q;

	logic en;
	logic vld_s [1:S_OUT];

	logic [47:0] phase_ext;
	logic [31:0] tfull_s1, tcos_s1, thalf_s1;

	logic signed [CW-1:0] x0_s [1:S_RX];
	logic signed [CW-1:0] y0_s [1:S_SIN];
	logic signed [CW-1:0] z0_s [1:S_SIN];

	logic signed [TW-1:0] sin_w, cos_w, sh_w;
	logic signed [TW-1:0] sn_s [S_SIN+1:S_RZ];
	logic signed [TW-1:0] cs_s [S_SIN+1:S_RY];
	logic signed [TW-1:0] sh_s [S_SIN+1:S_RZ];

	logic signed [CW-1:0] y1_w, z1_w, z2_w, x2_w, x3_w, y3_w;
	logic signed [CW-1:0] y1_s [S_RX+1:S_RY];
	logic signed [CW-1:0] z2_s [S_RY+1:S_RZ];

	logic signed [33:0] s_int, d_full;
	logic               d_low;
	logic signed [10:0] scale_sg, amp_sg;
	logic [vrp_pkg::DEN_W-1:0] d_s15, d_s16;
	logic signed [41:0] mx_s15, my_s15, sw_s15;
	logic               clip_s15;

	logic [vrp_pkg::MAG_W-1:0] magx, magy;
	logic [vrp_pkg::NUM_W-1:0] numx_s16, numy_s16;
	vrp_pkg::vrp_side_t side_s [S_ABS:S_DIV];

	logic [vrp_pkg::QUOT_W-1:0] qx_w, qy_w;
	logic signed [35:0] nx_w, ny_w;
	logic signed [39:0] tx_s52, ty_s52;
	logic               clip_s52;

	logic signed [39:0] tqx, tqy;
	logic               satx, saty;
	logic signed [PIXEL_BITS-1:0] px_s53, py_s53;
	logic               clip_s53;

	assign en       = !(vld_s[S_OUT] && out_stall);
	assign in_stall = vld_s[S_OUT] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= vrp_pkg::CENTER_X_RST;
			cy_q    <= vrp_pkg::CENTER_Y_RST;
			scale_q <= vrp_pkg::SCALE_RST;
			amp_q   <= vrp_pkg::SWAY_AMP_RST;
			eye_q   <= vrp_pkg::EYE_DIST_RST;
		end else if (cfg_wr_en) begin
			unique case (vrp_pkg::cfg_reg_t'(cfg_index))
				vrp_pkg::REG_CENTER_X:          cx_q    <= cfg_data[10:0];
				vrp_pkg::REG_CENTER_Y:          cy_q    <= cfg_data[10:0];
				vrp_pkg::REG_SCREEN_SCALE:      scale_q <= cfg_data[9:0];
				vrp_pkg::REG_SWAY_AMPLITUDE:    amp_q   <= cfg_data[9:0];
				vrp_pkg::REG_EYE_DISTANCE_BASE: eye_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= S_OUT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Phase bits from ANGLE_BITS-1 up shift out of the full turn, from ANGLE_BITS up out of the half turn.
	assign phase_ext = {32'd0, angle_phase};

	always_ff @(posedge clk) begin
		if (en) begin
			tfull_s1 <= 32'(phase_ext << (33 - ANGLE_BITS));
			tcos_s1  <= 32'(phase_ext << (33 - ANGLE_BITS)) + vrp_pkg::Q30_ONE;
			thalf_s1 <= 32'(phase_ext << (32 - ANGLE_BITS));
			x0_s[1]  <= CW'(vertex_x) <<< vrp_pkg::EXTRA_BITS;
			y0_s[1]  <= CW'(vertex_y) <<< vrp_pkg::EXTRA_BITS;
			z0_s[1]  <= CW'(vertex_z) <<< vrp_pkg::EXTRA_BITS;
			for (int k = 2; k <= S_RX; k++) begin
				x0_s[k] <= x0_s[k-1];
			end
			for (int k = 2; k <= S_SIN; k++) begin
				y0_s[k] <= y0_s[k-1];
				z0_s[k] <= z0_s[k-1];
			end
			sn_s[S_SIN+1] <= sin_w;
			cs_s[S_SIN+1] <= cos_w;
			sh_s[S_SIN+1] <= sh_w;
			for (int k = S_SIN + 2; k <= S_RZ; k++) begin
				sn_s[k] <= sn_s[k-1];
				sh_s[k] <= sh_s[k-1];
			end
			for (int k = S_SIN + 2; k <= S_RY; k++) begin
				cs_s[k] <= cs_s[k-1];
			end
			y1_s[S_RX+1] <= y1_w;
			for (int k = S_RX + 2; k <= S_RY; k++) begin
				y1_s[k] <= y1_s[k-1];
			end
			z2_s[S_RY+1] <= z2_w;
			for (int k = S_RY + 2; k <= S_RZ; k++) begin
				z2_s[k] <= z2_s[k-1];
			end
		end
	end

	vrp_sine u_sin (.clk(clk), .en(en), .turn(tfull_s1), .sine(sin_w));
	vrp_sine u_cos (.clk(clk), .en(en), .turn(tcos_s1),  .sine(cos_w));
	vrp_sine u_shf (.clk(clk), .en(en), .turn(thalf_s1), .sine(sh_w));

	vrp_rotate u_rot_x (
		.clk(clk), .en(en), .c(cos_w), .s(sin_w),
		.a(y0_s[S_SIN]), .b(z0_s[S_SIN]), .oa(y1_w), .ob(z1_w)
	);

	vrp_rotate u_rot_y (
		.clk(clk), .en(en), .c(cs_s[S_RX]), .s(sn_s[S_RX]),
		.a(z1_w), .b(x0_s[S_RX]), .oa(z2_w), .ob(x2_w)
	);

	vrp_rotate u_rot_z (
		.clk(clk), .en(en), .c(cs_s[S_RY]), .s(sn_s[S_RY]),
		.a(x2_w), .b(y1_s[S_RY]), .oa(x3_w), .ob(y3_w)
	);

	assign s_int    = (34'(sn_s[S_RZ]) + SINT_RND) >>> SINT_SH;
	assign d_full   = (signed'({18'd0, eye_q}) <<< CFB) + s_int - 34'(z2_s[S_RZ]);
	assign d_low    = d_full <= DMIN;
	assign scale_sg = signed'({1'b0, scale_q});
	assign amp_sg   = signed'({1'b0, amp_q});

	always_ff @(posedge clk) begin
		if (en) begin
			d_s15    <= d_low ? DMIN[vrp_pkg::DEN_W-1:0] : d_full[vrp_pkg::DEN_W-1:0];
			clip_s15 <= d_low;
			mx_s15   <= 42'(x3_w) * 42'(scale_sg);
			my_s15   <= 42'(y3_w) * 42'(scale_sg);
			sw_s15   <= 42'(sh_s[S_RZ]) * 42'(amp_sg);
		end
	end

	assign magx = mx_s15[41] ? vrp_pkg::MAG_W'(-mx_s15) : mx_s15[vrp_pkg::MAG_W-1:0];
	assign magy = my_s15[41] ? vrp_pkg::MAG_W'(-my_s15) : my_s15[vrp_pkg::MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s16               <= d_s15;
			numx_s16            <= {magx, 16'd0};
			numy_s16            <= {magy, 16'd0};
			side_s[S_ABS].neg_x <= mx_s15[41];
			side_s[S_ABS].neg_y <= my_s15[41];
			side_s[S_ABS].sway  <= vrp_pkg::SWAY_W'((sw_s15 + 42'sd8192) >>> 14);
			side_s[S_ABS].clip  <= clip_s15;
			for (int k = S_ABS + 1; k <= S_DIV; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	vrp_divide u_div (
		.clk(clk), .en(en), .den(d_s16), .num_x(numx_s16), .num_y(numy_s16),
		.quot_x(qx_w), .quot_y(qy_w)
	);

	assign nx_w = side_s[S_DIV].neg_x ? -signed'(36'(qx_w)) : signed'(36'(qx_w));
	assign ny_w = side_s[S_DIV].neg_y ? -signed'(36'(qy_w)) : signed'(36'(qy_w));

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s52   <= 40'(nx_w) + signed'(40'(cx_q) << 16) + 40'(side_s[S_DIV].sway);
			ty_s52   <= 40'(ny_w) + signed'(40'(cy_q) << 16);
			clip_s52 <= side_s[S_DIV].clip;
		end
	end

	// Division by 65536 truncates toward zero.
	assign tqx  = tx_s52[39] ? ((tx_s52 + 40'sd65535) >>> 16) : (tx_s52 >>> 16);
	assign tqy  = ty_s52[39] ? ((ty_s52 + 40'sd65535) >>> 16) : (ty_s52 >>> 16);
	assign satx = (tqx > PIX_HI) || (tqx < PIX_LO);
	assign saty = (tqy > PIX_HI) || (tqy < PIX_LO);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s53   <= (tqx > PIX_HI) ? PIXEL_BITS'(PIX_HI) :
			            (tqx < PIX_LO) ? PIXEL_BITS'(PIX_LO) : PIXEL_BITS'(tqx);
			py_s53   <= (tqy > PIX_HI) ? PIXEL_BITS'(PIX_HI) :
			            (tqy < PIX_LO) ? PIXEL_BITS'(PIX_LO) : PIXEL_BITS'(tqy);
			clip_s53 <= clip_s52 || satx || saty;
		end
	end

	assign out_valid = vld_s[S_OUT];
	assign pixel_x   = px_s53;
	assign pixel_y   = py_s53;
	assign clipped   = clip_s53;

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	a_frozen_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s[S_DIV]) && $stable(vld_s[S_MUL])))
		else $error("pipeline valid bits moved while frozen");

	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_MUL] |-> (d_s15 >= DMIN[vrp_pkg::DEN_W-1:0]))
		else $error("divisor below the depth floor");

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for the vertex rotate/project unit
// Drives vertices through the valid/stall input channel with random gaps,
// stalls the output at random between results (not while stall_on is clear),
// and compares every result against a fixed-point projection predictor over
// several register settings.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 53;

	typedef struct {
		logic signed [11:0] px;
		logic signed [11:0] py;
		logic               clip;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	logic [15:0] angle_phase = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [11:0] pixel_x, pixel_y;
	logic clipped;

	longint cx = 320, cy = 320, scl = 160, amp = 100, eye = 32768;
	pixel_t expected_pixels[$];
	int mismatches = 0;
	int out_wait = 0;
	bit stall_on = 1'b1;

	vertex_rotate_project_unit uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_shift(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint sine_q30(logic [31:0] turn);
		logic [63:0] x, x2, p, s;
		x = {34'd0, turn[29:0]};
		if (turn[30]) x = 64'h4000_0000 - x;
		x2 = (x * x) >> 30;
		p = vrp_pkg::SINE_POLY[4];
		p = vrp_pkg::SINE_POLY[3] - ((x2 * p) >> 30);
		p = vrp_pkg::SINE_POLY[2] - ((x2 * p) >> 30);
		p = vrp_pkg::SINE_POLY[1] - ((x2 * p) >> 30);
		p = vrp_pkg::SINE_POLY[0] - ((x2 * p) >> 30);
		s = (x * p) >> 30;
		if (s > 64'h4000_0000) s = 64'h4000_0000;
		return turn[31] ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint sat_pixel(longint v, ref bit clip);
		if (v > 2047) begin
			clip = 1'b1;
			return 2047;
		end
		if (v < -2048) begin
			clip = 1'b1;
			return -2048;
		end
		return v;
	endfunction

	function automatic pixel_t project_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] vz, logic [15:0] ph);
		logic [31:0] tf, th;
		longint s, c, sh, x0, y0, z0, y1, z1, x2, z2, x3, y3, d, nx, ny, tx, ty;
		bit clip;
		pixel_t r;
		clip = 1'b0;
		tf = {ph[14:0], 17'd0};
		th = {ph, 16'd0};
		s = sine_q30(tf);
		c = sine_q30(tf + 32'h4000_0000);
		sh = sine_q30(th);
		x0 = longint'(vx) <<< 14;
		y0 = longint'(vy) <<< 14;
		z0 = longint'(vz) <<< 14;
		y1 = round_shift(c * y0 - s * z0, 30);
		z1 = round_shift(s * y0 + c * z0, 30);
		z2 = round_shift(c * z1 - s * x0, 30);
		x2 = round_shift(s * z1 + c * x0, 30);
		x3 = round_shift(c * x2 - s * y1, 30);
		y3 = round_shift(s * x2 + c * y1, 30);
		d = (eye <<< 14) + round_shift(s, 2) - z2;
		if (d <= (longint'(1) << 22)) begin
			d = longint'(1) << 22;
			clip = 1'b1;
		end
		nx = (x3 * scl * 65536) / d;
		ny = (y3 * scl * 65536) / d;
		tx = nx + (cx <<< 16) + round_shift(amp * sh, 14);
		ty = ny + (cy <<< 16);
		r.px = 12'(sat_pixel(tx / 65536, clip));
		r.py = 12'(sat_pixel(ty / 65536, clip));
		r.clip = clip;
		return r;
	endfunction

	task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] vz, logic [15:0] ph);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= vx;
		vertex_y <= vy;
		vertex_z <= vz;
		angle_phase <= ph;
		do @(posedge clk); while (in_stall);
		expected_pixels.push_back(project_vertex(vx, vy, vz, ph));
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_reg(vrp_pkg::cfg_reg_t idx, longint val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			vrp_pkg::REG_CENTER_X: cx = val & 'h7FF;
			vrp_pkg::REG_CENTER_Y: cy = val & 'h7FF;
			vrp_pkg::REG_SCREEN_SCALE: scl = val & 'h3FF;
			vrp_pkg::REG_SWAY_AMPLITUDE: amp = val & 'h3FF;
			default: eye = val & 'hFFFF;
		endcase
	endtask

	task automatic set_all(longint a, longint b, longint c, longint d, longint e);
		drain_pipeline();
		write_reg(vrp_pkg::REG_CENTER_X, a);
		write_reg(vrp_pkg::REG_CENTER_Y, b);
		write_reg(vrp_pkg::REG_SCREEN_SCALE, c);
		write_reg(vrp_pkg::REG_SWAY_AMPLITUDE, d);
		write_reg(vrp_pkg::REG_EYE_DISTANCE_BASE, e);
	endtask

	task automatic test_directed();
		logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		for (int i = 0; i < 4; i++) send_vertex(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
			ext[(i + 3) % 4]);
		send_vertex(16'sd16384, 16'sd0, 16'sd0, 16'd0);
		send_vertex(16'sd0, 16'sd16384, 16'sd0, 16'd16384);
		send_vertex(16'sd0, 16'sd0, 16'sd32767, 16'd0);
		send_vertex(16'sd0, 16'sd0, -16'sd32768, 16'd32768);
		send_vertex(16'sd32767, 16'sd32767, 16'sd32767, 16'd8192);
		send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, 16'd49152);
		send_vertex(16'sd100, -16'sd100, 16'sd0, 16'd65535);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_vertex(16'($signed($urandom_range(0, 16384)) - 8192),
					16'($signed($urandom_range(0, 16384)) - 8192),
					16'($signed($urandom_range(0, 16384)) - 8192), 16'($urandom));
		end
	endtask

	task automatic test_near_plane();
		for (int i = 0; i < 40; i++)
			send_vertex(16'($urandom), 16'($urandom), 16'($signed($urandom_range(20000, 32767))),
				16'($urandom_range(0, 3)));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(300);
		set_all(0, 0, 0, 0, 0);
		test_near_plane();
		test_random(150);
		set_all(2047, 2047, 1023, 1023, 65535);
		test_directed();
		test_random(200);
		stall_on = 1'b0;
		set_all(1024, 200, 512, 37, 16384);
		test_near_plane();
		test_random(200);
		stall_on = 1'b1;
		set_all(320, 320, 160, 100, 32768);
		test_random(200);
		drain_pipeline();
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// Each transfer draws a fresh number of stall cycles for the results that follow; none while stall_on is clear.
	always @(negedge clk) begin
		if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid && !out_stall) begin
			out_wait = stall_on ? $urandom_range(0, 7) : 0;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer x=%0d y=%0d", pixel_x, pixel_y);
			end else begin
				e = expected_pixels.pop_front();
				if (pixel_x !== e.px || pixel_y !== e.py || clipped !== e.clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%0d y=%0d c=%0b, got x=%0d y=%0d c=%0b",
							e.px, e.py, e.clip, pixel_x, pixel_y, clipped);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end
endmodule
